/* src/positional_list_store_assert.svh */
// Assertion macros used by the RTL datapath (plst_dp.sv).
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PLST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_list_store: assertion failed");

// Next-cycle implication, checked out of reset.
`define PLST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_list_store: assertion failed");

`endif

/* src/plst_pkg.sv */
package plst_pkg;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned InDataWidth = 32;
  localparam int unsigned PosWidth    = 8;
  localparam int unsigned CountWidth  = 5;

  typedef enum logic [OpWidth-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_POS   = 3'd1,
    OP_APPEND    = 3'd2,
    OP_DEL_POS   = 3'd3,
    OP_DUMP      = 3'd4
  } op_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic more;
  } dp_status_t;

endpackage

/* src/plst_ctrl.sv */
module plst_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  plst_pkg::dp_status_t  dp_st,
  output plst_pkg::ctl_cmd_t    cmd
);
  import plst_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dp_st.out_free && !dp_st.more) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = dp_st.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

/* src/plst_dp.sv */
`include "positional_list_store_assert.svh"

module plst_dp #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [plst_pkg::OpWidth-1:0]           in_opcode,
  input  logic [plst_pkg::InDataWidth-1:0]       in_data_value,
  input  logic signed [plst_pkg::PosWidth-1:0]   in_position,
  input  plst_pkg::ctl_cmd_t                     cmd,
  output plst_pkg::dp_status_t                   dp_st,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic [plst_pkg::StatusWidth-1:0]       out_status,
  output logic [plst_pkg::InDataWidth-1:0]       out_entry_value,
  output logic [plst_pkg::CountWidth-1:0]        out_entry_count,
  output logic                                   out_last_result
);
  import plst_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CMPW = PosWidth;

  logic [DATA_WIDTH-1:0]  entries_r [CAPACITY];
  logic [DATA_WIDTH-1:0]  entries_nxt [CAPACITY];
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  op_t                    op_r;
  logic [DATA_WIDTH-1:0]  data_r;
  logic [PosWidth-1:0]    pos_r;
  logic [IW-1:0]          dump_idx_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [InDataWidth-1:0] out_value_r;
  logic [CountWidth-1:0]  out_count_r;
  logic                   out_last_r;

  logic [DATA_WIDTH+InDataWidth-1:0] data_ext;
  logic [DATA_WIDTH+InDataWidth-1:0] entry_ext;
  logic [CMPW-1:0]        count_ext;
  logic [CMPW-1:0]        dump_ext;
  logic [CMPW-1:0]        ins_idx;
  logic                   neg;
  logic                   full;
  logic                   ins_we;
  logic                   del_we;
  logic                   more;
  status_t                res_status;

  assign data_ext  = {{DATA_WIDTH{1'b0}}, in_data_value};
  assign entry_ext = {{InDataWidth{1'b0}}, entries_r[dump_idx_r]};
  assign count_ext = {{(CMPW-CW){1'b0}}, count_r};
  assign dump_ext  = {{(CMPW-IW){1'b0}}, dump_idx_r};
  assign neg       = pos_r[PosWidth-1];
  assign full      = (count_ext == CMPW'(CAPACITY));
  assign more      = (op_r == OP_DUMP) && ((dump_ext + CMPW'(1)) < count_ext);

  always_comb begin
    ins_idx    = count_ext;
    ins_we     = 1'b0;
    del_we     = 1'b0;
    res_status = ST_BAD_POS;
    count_nxt  = count_r;
    unique case (op_r) inside
      OP_INS_FRONT, OP_INS_POS, OP_APPEND: begin
        if (op_r == OP_INS_FRONT) begin
          ins_idx = '0;
        end else if (op_r == OP_INS_POS) begin
          ins_idx = pos_r;
        end
        if (op_r == OP_INS_POS && (neg || pos_r > count_ext)) begin
          res_status = ST_BAD_POS;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          ins_we     = cmd.exec;
          count_nxt  = count_r + CW'(1);
        end
      end
      OP_DEL_POS: begin
        if (neg || pos_r >= count_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          res_status = ST_OK;
          del_we     = cmd.exec;
          count_nxt  = count_r - CW'(1);
        end
      end
      OP_DUMP: begin
        res_status = (count_r == '0) ? ST_EMPTY : ST_OK;
      end
      default: res_status = ST_BAD_POS;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      entries_nxt[i] = entries_r[i];
      if (ins_we) begin
        if (CMPW'(i) == ins_idx) begin
          entries_nxt[i] = data_r;
        end else if (CMPW'(i) > ins_idx) begin
          entries_nxt[i] = entries_r[(i == 0) ? 0 : i - 1];
        end
      end else if (del_we && (i < CAPACITY - 1) && (CMPW'(i) >= pos_r)) begin
        entries_nxt[i] = entries_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      entries_r[i] <= entries_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= op_t'(in_opcode);
      data_r     <= data_ext[DATA_WIDTH-1:0];
      pos_r      <= in_position;
      dump_idx_r <= '0;
    end else if (cmd.exec && more) begin
      dump_idx_r <= dump_idx_r + IW'(1);
    end
    if (cmd.exec) begin
      out_status_r <= res_status;
      out_value_r  <= (op_r == OP_DUMP && count_r != '0) ?
                      entry_ext[InDataWidth-1:0] : '0;
      out_count_r  <= CountWidth'(count_nxt);
      out_last_r   <= !more;
    end
  end

  assign dp_st.out_free   = !out_valid_r || !out_stall;
  assign dp_st.more       = more;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_value  = out_value_r;
  assign out_entry_count  = out_count_r;
  assign out_last_result  = out_last_r;

  `PLST_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY))
  `PLST_ASSERT_NOW(a_exec_needs_room, cmd.exec, dp_st.out_free)
  `PLST_ASSERT_NEXT(a_exec_fills_out, cmd.exec, out_valid_r)
  `PLST_ASSERT_NEXT(a_count_only_on_exec, !cmd.exec, $stable(count_r))

endmodule

/* src/positional_list_store.sv */
// Ordered list store of up to CAPACITY words with positional insert and delete.
// Input channel: in_valid/in_stall with in_opcode, in_data_value, in_position.
// Result channel: out_valid/out_stall with out_status, out_entry_value,
// out_entry_count and out_last_result.
// A request is captured into the op, data and position registers and executed
// once the result register is free, where the cells at and above the insert or
// delete position shift by one place at once; the first result beat is
// registered at that execution edge. Insert, append and delete give a single
// beat; a new request is accepted only once the previous one has executed.
// A dump gives one beat per held entry, one per cycle while the result channel
// is not stalled, read from the cell row; the last beat has out_last_result set,
// and an empty list gives one beat with the empty status. A dump keeps the input
// stalled until its last beat is registered. While out_stall is high and a beat
// is held, the result register keeps it and execution waits, so a request that
// has been taken keeps in_stall high until its result can move.
// Synchronous reset empties the list, clears out_valid and leaves the input
// ready; the cell contents are not cleared and are never read before they
// are written.
module positional_list_store #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [plst_pkg::OpWidth-1:0]          in_opcode,
  input  logic [plst_pkg::InDataWidth-1:0]      in_data_value,
  input  logic signed [plst_pkg::PosWidth-1:0]  in_position,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [plst_pkg::StatusWidth-1:0]      out_status,
  output logic [plst_pkg::InDataWidth-1:0]      out_entry_value,
  output logic [plst_pkg::CountWidth-1:0]       out_entry_count,
  output logic                                  out_last_result
);
  import plst_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t dp_st;

  plst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_st    (dp_st),
    .cmd      (cmd)
  );

  plst_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_data_value   (in_data_value),
    .in_position     (in_position),
    .cmd             (cmd),
    .dp_st           (dp_st),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count),
    .out_last_result (out_last_result)
  );

endmodule

/* tb/sv/positional_list_store_tb.sv */
module positional_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plst_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    status_t                status;
    logic [InDataWidth-1:0] value;
    logic [CountWidth-1:0]  count;
    logic                   last;
  } beat_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [OpWidth-1:0]          in_opcode;
  logic [InDataWidth-1:0]      in_data_value;
  logic signed [PosWidth-1:0]  in_position;
  logic                        out_valid;
  logic                        out_stall;
  logic [StatusWidth-1:0]      out_status;
  logic [InDataWidth-1:0]      out_entry_value;
  logic [CountWidth-1:0]       out_entry_count;
  logic                        out_last_result;

  logic [InDataWidth-1:0] list_model [CAPACITY];
  int unsigned            held_count;
  beat_t                  pending_beats [$];
  int unsigned            error_count;
  bit                     quiet;

  positional_list_store dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_data_value   (in_data_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count),
    .out_last_result (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void queue_beat(status_t st, logic [InDataWidth-1:0] val, logic last);
    beat_t b;
    b.status = st;
    b.value  = val;
    b.count  = CountWidth'(held_count);
    b.last   = last;
    pending_beats.push_back(b);
  endfunction

  function automatic status_t insert_entry(int unsigned idx, logic [InDataWidth-1:0] data);
    if (idx > held_count) return ST_BAD_POS;
    if (held_count >= CAPACITY) return ST_FULL;
    for (int unsigned i = held_count; i > idx; i--) list_model[i] = list_model[i-1];
    list_model[idx] = data;
    held_count++;
    return ST_OK;
  endfunction

  function automatic void predict_request(logic [OpWidth-1:0] op, logic [InDataWidth-1:0] data,
                                          logic signed [PosWidth-1:0] pos);
    status_t     st;
    int unsigned idx;
    st  = ST_BAD_POS;
    idx = pos[PosWidth-2:0];
    if (op == OP_DUMP) begin
      if (held_count == 0) begin
        queue_beat(ST_EMPTY, '0, 1'b1);
      end else begin
        for (int unsigned i = 0; i < held_count; i++)
          queue_beat(ST_OK, list_model[i], i + 1 == held_count);
      end
    end else begin
      case (op)
        OP_INS_FRONT: begin
          st = insert_entry(0, data);
        end
        OP_INS_POS: begin
          if (!pos[PosWidth-1]) st = insert_entry(idx, data);
        end
        OP_APPEND: begin
          st = insert_entry(held_count, data);
        end
        OP_DEL_POS: begin
          if (!pos[PosWidth-1] && idx < held_count) begin
            for (int unsigned i = idx; i + 1 < held_count; i++) list_model[i] = list_model[i+1];
            held_count--;
            st = ST_OK;
          end
        end
        default: begin
          st = ST_BAD_POS;
        end
      endcase
      queue_beat(st, '0, 1'b1);
    end
  endfunction

  task automatic send_request(input logic [OpWidth-1:0] op, input logic [InDataWidth-1:0] data,
                              input logic signed [PosWidth-1:0] pos);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_data_value <= data;
    in_position   <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, data, pos);
  endtask

  always @(posedge clk) begin : result_checker
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected result beat: status %0d value %h count %0d last %0b",
                   out_status, out_entry_value, out_entry_count, out_last_result);
      end else begin
        want = pending_beats.pop_front();
        if (out_status !== want.status || out_entry_value !== want.value ||
            out_entry_count !== want.count || out_last_result !== want.last) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("result mismatch: expected status %0d value %h count %0d last %0b,",
                     want.status, want.value, want.count, want.last,
                     " got status %0d value %h count %0d last %0b",
                     out_status, out_entry_value, out_entry_count, out_last_result);
        end
      end
    end
  end

  initial begin : result_stall_driver
    int unsigned hold;
    out_stall = 1'b0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic test_empty_list();
    send_request(OP_DUMP, $urandom(), 8'sd0);
    send_request(OP_DEL_POS, $urandom(), 8'sd0);
    send_request(OP_INS_POS, $urandom(), 8'sd1);
  endtask

  task automatic test_insert_ops();
    send_request(OP_INS_FRONT, 32'hFFFF_FFFF, 8'sd0);
    send_request(OP_APPEND, 32'h0000_0000, 8'sd0);
    send_request(OP_INS_POS, $urandom(), 8'sd1);
    send_request(OP_INS_POS, $urandom(), PosWidth'(held_count));
    send_request(OP_INS_POS, $urandom(), -8'sd1);
    send_request(OP_INS_POS, $urandom(), -8'sd128);
    send_request(OP_INS_POS, $urandom(), 8'sd127);
    send_request(OP_DUMP, $urandom(), 8'sd0);
  endtask

  task automatic test_delete_ops();
    send_request(OP_DEL_POS, $urandom(), -8'sd1);
    send_request(OP_DEL_POS, $urandom(), PosWidth'(held_count));
    send_request(OP_DEL_POS, $urandom(), 8'sd0);
    send_request(OP_DEL_POS, $urandom(), PosWidth'(held_count - 1));
    send_request(OP_DUMP, $urandom(), 8'sd0);
  endtask

  task automatic test_unused_ops();
    for (int op = OP_DUMP + 1; op < (1 << OpWidth); op++)
      send_request(OpWidth'(op), $urandom(), PosWidth'($urandom()));
  endtask

  task automatic test_full_list();
    while (held_count < CAPACITY) begin
      case ($urandom_range(0, 2))
        0: send_request(OP_INS_FRONT, $urandom(), PosWidth'($urandom()));
        1: send_request(OP_INS_POS, $urandom(), PosWidth'($urandom_range(0, held_count)));
        default: send_request(OP_APPEND, $urandom(), PosWidth'($urandom()));
      endcase
    end
    send_request(OP_INS_FRONT, $urandom(), 8'sd0);
    send_request(OP_INS_POS, $urandom(), PosWidth'(held_count + 1));
    send_request(OP_INS_POS, $urandom(), 8'sd0);
    send_request(OP_APPEND, $urandom(), 8'sd0);
    send_request(OP_DUMP, $urandom(), 8'sd0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned                r;
    logic [OpWidth-1:0]         op;
    logic signed [PosWidth-1:0] pos;
    for (int unsigned k = 0; k < n_items; k++) begin
      quiet = (k >= 60 && k < 90);
      r   = $urandom_range(0, 99);
      pos = PosWidth'($urandom());
      if (r < 10) begin
        op = OP_INS_FRONT;
      end else if (r < 26) begin
        op = OP_INS_POS;
        if ($urandom_range(0, 99) < 85) pos = PosWidth'($urandom_range(0, held_count));
      end else if (r < 38) begin
        op = OP_APPEND;
      end else if (r < 70) begin
        op = OP_DEL_POS;
        if (held_count > 0 && $urandom_range(0, 99) < 85)
          pos = PosWidth'($urandom_range(0, held_count - 1));
      end else if (r < 84) begin
        op = OP_DUMP;
      end else begin
        op = OpWidth'($urandom_range(0, (1 << OpWidth) - 1));
      end
      send_request(op, $urandom(), pos);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = '0;
    in_data_value = '0;
    in_position   = '0;
    quiet         = 1'b0;
    held_count    = 0;
    error_count   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_insert_ops();
    test_delete_ops();
    test_unused_ops();
    test_full_list();
    test_random_traffic(160);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* positional_list_store.f */
+incdir+src
src/plst_pkg.sv
src/plst_ctrl.sv
src/plst_dp.sv
src/positional_list_store.sv
tb/sv/positional_list_store_tb.sv
